// ===== sv/vpid_pkg.sv =====
// Shared constants, types and a helper function of the velocity PID controller.
package vpid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int HP_BITS    = 32;

    // Multiplier operand width: holds a difference of two data words and the
    // zero-extended half-period register.
    localparam int OP_W   = ((DATA_WIDTH > HP_BITS) ? DATA_WIDTH : HP_BITS) + 1;
    localparam int PROD_W = 2 * OP_W;
    // Width of sums of up to three saturated data words.
    localparam int VS_W   = DATA_WIDTH + 2;

    localparam int CFG_W     = (DATA_WIDTH > HP_BITS) ? DATA_WIDTH : HP_BITS;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 3'd4;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] gain_p;
        logic signed [DATA_WIDTH-1:0] gain_i;
        logic signed [DATA_WIDTH-1:0] gain_d;
        logic [DATA_WIDTH-2:0]        sample_rate;
        logic [HP_BITS-1:0]           half_period;
    } cfg_t;

    typedef struct packed {
        logic en;
        logic sh_long;
    } mul_req_t;

    localparam logic signed [VS_W-1:0] VS_MAX =
        {{(VS_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [VS_W-1:0] VS_MIN = ~VS_MAX;
    localparam logic signed [DATA_WIDTH-1:0] DW_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DW_MIN = ~DW_MAX;

    // Clamp a wide sum to the signed data range.
    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [VS_W-1:0] x);
        logic signed [DATA_WIDTH-1:0] r;
        if (x > VS_MAX)
        begin
            r = DW_MAX;
        end
        else if (x < VS_MIN)
        begin
            r = DW_MIN;
        end
        else
        begin
            r = x[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/vpid_if.sv =====
// Valid/ready channel interfaces for update requests and control results.
interface vpid_in_if;
    import vpid_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [DATA_WIDTH-1:0] error_sample;

    modport source (output valid, output kind, output error_sample, input ready);
    modport sink   (input valid, input kind, input error_sample, output ready);
endinterface

interface vpid_out_if;
    import vpid_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] control_output;
    logic                         saturated;

    modport source (output valid, output control_output, output saturated, input ready);
    modport sink   (input valid, input control_output, input saturated, output ready);
endinterface

// ===== sv/vpid_cfg_regs.sv =====
// Configuration register file: gains, sample rate and half period.
module vpid_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [vpid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vpid_pkg::CFG_W-1:0]       cfg_data,
    output vpid_pkg::cfg_t                   cfg
);
    import vpid_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_data[DATA_WIDTH-1:0];
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_data[DATA_WIDTH-1:0];
                REG_GAIN_D:      cfg_reg.gain_d      <= cfg_data[DATA_WIDTH-1:0];
                REG_SAMPLE_RATE: cfg_reg.sample_rate <= cfg_data[DATA_WIDTH-2:0];
                REG_HALF_PERIOD: cfg_reg.half_period <= cfg_data[HP_BITS-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/vpid_mul_unit.sv =====
// Shared fixed-point multiplier: registered product, then truncation and clamping.
module vpid_mul_unit (
    input  logic                                clk,
    input  vpid_pkg::mul_req_t                  req,
    input  logic signed [vpid_pkg::OP_W-1:0]    opa,
    input  logic signed [vpid_pkg::OP_W-1:0]    opb,
    output logic signed [vpid_pkg::DATA_WIDTH-1:0] res,
    output logic                                hit
);
    import vpid_pkg::*;

    localparam logic signed [PROD_W-1:0] BIAS_F = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] BIAS_H = (PROD_W'(1) << HP_BITS) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] P_MAX  =
        {{(PROD_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] P_MIN  = ~P_MAX;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     sh_long_reg;
    logic signed [PROD_W-1:0] bias;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg    <= PROD_W'(opa) * PROD_W'(opb);
            sh_long_reg <= req.sh_long;
        end
    end

    // Adding the shift mask to a negative product makes the arithmetic
    // shift round toward zero.
    always_comb
    begin
        if (prod_reg[PROD_W-1])
        begin
            bias = sh_long_reg ? BIAS_H : BIAS_F;
        end
        else
        begin
            bias = '0;
        end
        biased  = prod_reg + bias;
        shifted = sh_long_reg ? (biased >>> HP_BITS) : (biased >>> FRAC_BITS);
        hit     = (shifted > P_MAX) || (shifted < P_MIN);
        if (shifted > P_MAX)
        begin
            res = DW_MAX;
        end
        else if (shifted < P_MIN)
        begin
            res = DW_MIN;
        end
        else
        begin
            res = shifted[DATA_WIDTH-1:0];
        end
    end

endmodule

// ===== sv/velocity_pid_controller_top.sv =====
// Velocity-form PID controller top level: sequencer, state and output register.
//
// Each transaction on the input channel is either an update carrying an error
// sample or a clear of the output accumulator, and yields one result
// transaction. An update's result is loaded into the output register as the
// sequencer leaves S_DONE, and the next transaction can be accepted in the
// cycle after that. From acceptance to S_DONE, six products (rate term, second
// difference, three gain products and the trapezoid increment) pass one at a
// time through a single shared multiplier with a registered product, under a
// small sequencer, with wait cycles where a product feeds the next operand or
// the velocity sum. A clear's result is loaded as the sequencer leaves S_CLR.
// A result that cannot leave because the output register is still full holds
// the sequencer in its last state. The input is ready only while the sequencer
// is idle; a finished result waits in the output register while the next
// transaction is accepted. Configuration is written through a plain write
// port and takes effect in every later sequencer state that reads it, also
// within an update that is running.
module velocity_pid_controller_top (
    input  logic                           clk,
    input  logic                           rst_n,
    vpid_in_if.sink                        in_ch,
    vpid_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [vpid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vpid_pkg::CFG_W-1:0]     cfg_data
);
    import vpid_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MP,
        S_MI,
        S_MGP,
        S_MD,
        S_WD,
        S_MGD,
        S_V,
        S_H,
        S_MH,
        S_DONE,
        S_CLR
    } state_t;

    cfg_t     cfg;
    mul_req_t mul_req;
    logic signed [DATA_WIDTH-1:0] mul_res;
    logic                         mul_hit;

    state_t state_reg, state_next;
    logic signed [OP_W-1:0]       opa_reg, opa_next;
    logic signed [OP_W-1:0]       opb_reg, opb_next;
    logic                         sh_long_reg, sh_long_next;
    logic signed [DATA_WIDTH-1:0] e_reg, e_next;
    logic signed [DATA_WIDTH-1:0] p_reg, p_next;
    logic signed [VS_W-1:0]       vsum_reg, vsum_next;
    logic signed [DATA_WIDTH-1:0] v_reg, v_next;
    logic signed [DATA_WIDTH-1:0] prev_e_reg, prev_e_next;
    logic signed [DATA_WIDTH-1:0] prev_p_reg, prev_p_next;
    logic signed [DATA_WIDTH-1:0] prev_v_reg, prev_v_next;
    logic signed [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic                         out_sat_reg, out_sat_next;

    logic signed [OP_W-1:0]       rate_op;
    logic signed [VS_W-1:0]       v_total;
    logic signed [VS_W-1:0]       acc_sum;
    logic signed [DATA_WIDTH-1:0] acc_sat;
    logic                         out_free;

    vpid_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vpid_mul_unit u_mul (
        .clk (clk),
        .req (mul_req),
        .opa (opa_reg),
        .opb (opb_reg),
        .res (mul_res),
        .hit (mul_hit)
    );

    assign rate_op  = $signed(OP_W'(cfg.sample_rate));
    assign v_total  = vsum_reg + VS_W'(mul_res);
    assign acc_sum  = VS_W'(acc_reg) + VS_W'(mul_res);
    assign acc_sat  = sat_dw(acc_sum);
    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        sh_long_next   = sh_long_reg;
        e_next         = e_reg;
        p_next         = p_reg;
        vsum_next      = vsum_reg;
        v_next         = v_reg;
        prev_e_next    = prev_e_reg;
        prev_p_next    = prev_p_reg;
        prev_v_next    = prev_v_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        out_sat_next   = out_sat_reg;
        mul_req.en      = 1'b0;
        mul_req.sh_long = sh_long_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.kind == KIND_CLEAR)
                    begin
                        state_next = S_CLR;
                    end
                    else
                    begin
                        e_next       = in_ch.error_sample;
                        opa_next     = OP_W'(in_ch.error_sample) - OP_W'(prev_e_reg);
                        opb_next     = rate_op;
                        sh_long_next = 1'b0;
                        state_next   = S_MP;
                    end
                end
            end
            S_MP:
            begin
                mul_req.en = 1'b1;
                opa_next   = OP_W'(cfg.gain_i);
                opb_next   = OP_W'(e_reg);
                state_next = S_MI;
            end
            S_MI:
            begin
                // The rate term leaves the multiplier while the integral
                // product goes in.
                mul_req.en = 1'b1;
                p_next     = mul_res;
                opa_next   = OP_W'(cfg.gain_p);
                opb_next   = OP_W'(mul_res);
                state_next = S_MGP;
            end
            S_MGP:
            begin
                mul_req.en = 1'b1;
                vsum_next  = VS_W'(mul_res);
                opa_next   = OP_W'(p_reg) - OP_W'(prev_p_reg);
                opb_next   = rate_op;
                state_next = S_MD;
            end
            S_MD:
            begin
                mul_req.en = 1'b1;
                vsum_next  = vsum_reg + VS_W'(mul_res);
                state_next = S_WD;
            end
            S_WD:
            begin
                opa_next   = OP_W'(cfg.gain_d);
                opb_next   = OP_W'(mul_res);
                state_next = S_MGD;
            end
            S_MGD:
            begin
                mul_req.en = 1'b1;
                state_next = S_V;
            end
            S_V:
            begin
                v_next     = sat_dw(v_total);
                state_next = S_H;
            end
            S_H:
            begin
                opa_next     = OP_W'(v_reg) + OP_W'(prev_v_reg);
                opb_next     = $signed(OP_W'(cfg.half_period));
                sh_long_next = 1'b1;
                state_next   = S_MH;
            end
            S_MH:
            begin
                mul_req.en = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    acc_next       = acc_sat;
                    out_valid_next = 1'b1;
                    out_data_next  = acc_sat;
                    out_sat_next   = mul_hit || (VS_W'(acc_sat) != acc_sum);
                    prev_e_next    = e_reg;
                    prev_p_next    = p_reg;
                    prev_v_next    = v_reg;
                    state_next     = S_IDLE;
                end
            end
            S_CLR:
            begin
                if (out_free)
                begin
                    acc_next       = '0;
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_sat_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_e_reg    <= '0;
            prev_p_reg    <= '0;
            prev_v_reg    <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_e_reg    <= prev_e_next;
            prev_p_reg    <= prev_p_next;
            prev_v_reg    <= prev_v_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        sh_long_reg  <= sh_long_next;
        e_reg        <= e_next;
        p_reg        <= p_next;
        vsum_reg     <= vsum_next;
        v_reg        <= v_next;
        out_data_reg <= out_data_next;
        out_sat_reg  <= out_sat_next;
    end

    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.control_output = out_data_reg;
    assign out_ch.saturated      = out_sat_reg;

endmodule
